/* src/assert_macros.svh */
// Assertion helpers, sampled on the rising clock edge and off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("check failed");

`define CHK_NEVER(lbl, clk, rst_n, cond) \
	`CHK_PROP(lbl, clk, rst_n, !(cond))

`endif

/* src/dbpi_pkg.sv */
package dbpi_pkg;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [63:0] prod_t;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 136;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam q16_t Q16_MAX = 32'sh7fff_ffff;
	localparam q16_t Q16_MIN = 32'sh8000_0000;

	localparam logic [2:0] KIND_HIGH = 3'b001;
	localparam logic [2:0] KIND_LOW  = 3'b111;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEGRAL_GAIN  = 3'd1,
		REG_SAMPLE_PERIOD  = 3'd2,
		REG_DEAD_BAND      = 3'd3,
		REG_DIRECT_ACTION  = 3'd4,
		REG_LOOP_KIND      = 3'd5,
		REG_LOOP_ON        = 3'd6,
		REG_DERIVATIVE_OFF = 3'd7
	} cfg_reg_t;

	// floor(p / 2^16), saturated to Q16.16
	function automatic q16_t sat_shift16(prod_t p);
		logic [16:0] hi;
		hi = p[63:47];
		if ((&hi) || (~|hi))
			return q16_t'(p[47:16]);
		else if (p[63])
			return Q16_MIN;
		else
			return Q16_MAX;
	endfunction

	function automatic q16_t sat34(logic signed [33:0] v);
		if ((&v[33:31]) || (~|v[33:31]))
			return q16_t'(v[31:0]);
		else if (v[33])
			return Q16_MIN;
		else
			return Q16_MAX;
	endfunction

	function automatic q16_t sat33(logic signed [32:0] v);
		if (v[32] == v[31])
			return q16_t'(v[31:0]);
		else if (v[32])
			return Q16_MIN;
		else
			return Q16_MAX;
	endfunction

endpackage

/* src/deadband_pi_increment.sv */
// Velocity-form PI step with an error deadband.
// s_axis carries one sample request: setpoint, measured, derivative_term and
// limit_active. m_axis returns one result request per sample: error after
// deadband, proportional term, integral increment, P plus D, direction flag
// and the updated flag. cfg_wr_en/cfg_addr/cfg_wdata write the eight
// setup registers; write them only while the block is idle.
// With the loop on, a sample passes error/deadband, three products on one
// shared 32x32 multiplier and the final add before m_axis_tvalid rises;
// with the loop off the held values come back; with the gain at or below
// GAIN_FLOOR the error value is held, the P, I and drive terms come back
// zero and goal_down is set. A new sample is taken only once the last one
// has left the sequencer: s_axis_tready is high only while it is idle.
// The held results double as the output register: a finished result waits
// there while m_axis_tready is low, and a new sample may already be taken;
// its last step waits until the pending result is taken.
// Reset clears the held results and the registers to their defaults
// (direct action, high-limit loop kind, loop off).
`include "assert_macros.svh"

module deadband_pi_increment #(
	parameter int GAIN_FLOOR = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [dbpi_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [dbpi_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// setpoint[31:0], measured[63:32], derivative_term[95:64], limit_active[96]
	input  logic [dbpi_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// error_value[31:0], prop_term[63:32], integral_step[95:64],
	// drive_term[127:96], goal_down[128], updated[129]
	output logic [dbpi_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import dbpi_pkg::*;

	localparam q16_t GAIN_FLOOR_Q = q16_t'(GAIN_FLOOR);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERR,
		S_MULP,
		S_MULI,
		S_SATI,
		S_MULT,
		S_DONE
	} state_t;

	// setup registers
	q16_t        prop_gain_q;
	q16_t        integral_gain_q;
	logic [30:0] sample_period_q;
	logic [30:0] dead_band_q;
	logic        direct_action_q;
	logic [2:0]  loop_kind_q;
	logic        loop_on_q;
	logic        derivative_off_q;

	state_t      state_q;
	logic        m_valid_q;
	q16_t        held_error_q;
	q16_t        held_prop_q;
	q16_t        held_step_q;
	q16_t        held_drive_q;
	logic        held_goal_q;
	logic        updated_q;

	// working registers
	logic signed [32:0] diff_q;
	q16_t               deriv_q;
	logic               lim_q;
	q16_t               err_q;
	logic               in_band_q;
	q16_t               pterm_q;
	q16_t               iterm_q;

	logic               accept;
	logic               out_free;
	logic               gain_ok;
	logic signed [32:0] sp_e;
	logic signed [32:0] pv_e;
	logic signed [33:0] diff_e;
	logic signed [33:0] db_e;
	logic signed [33:0] d_minus;
	logic signed [33:0] d_plus;
	logic               mul_en;
	q16_t               mul_a;
	q16_t               mul_b;
	prod_t              mul_p;
	q16_t               d_sel;
	logic               goal_next;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign gain_ok  = prop_gain_q > GAIN_FLOOR_Q;

	assign sp_e    = 33'(signed'(s_axis_tdata[31:0]));
	assign pv_e    = 33'(signed'(s_axis_tdata[63:32]));
	assign diff_e  = 34'(diff_q);
	assign db_e    = signed'({3'b000, dead_band_q});
	assign d_minus = diff_e - db_e;
	assign d_plus  = diff_e + db_e;

	always_comb begin
		mul_en = 1'b0;
		mul_a  = prop_gain_q;
		mul_b  = err_q;
		case (state_q)
			S_MULP: begin
				mul_en = 1'b1;
			end
			S_MULI: begin
				mul_en = 1'b1;
				mul_a  = integral_gain_q;
			end
			S_MULT: begin
				mul_en = 1'b1;
				mul_a  = iterm_q;
				mul_b  = signed'({1'b0, sample_period_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	dbpi_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign d_sel = derivative_off_q ? '0 : deriv_q;

	always_comb begin
		goal_next = held_goal_q;
		if (in_band_q) begin
			if (loop_kind_q == KIND_HIGH)
				goal_next = (lim_q == direct_action_q);
			else if (loop_kind_q == KIND_LOW)
				goal_next = (lim_q != direct_action_q);
		end else begin
			goal_next = !(pterm_q > 0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= '0;
			integral_gain_q  <= '0;
			sample_period_q  <= '0;
			dead_band_q      <= '0;
			direct_action_q  <= 1'b1;
			loop_kind_q      <= KIND_HIGH;
			loop_on_q        <= 1'b0;
			derivative_off_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_addr))
				REG_PROP_GAIN:      prop_gain_q      <= q16_t'(cfg_wdata);
				REG_INTEGRAL_GAIN:  integral_gain_q  <= q16_t'(cfg_wdata);
				REG_SAMPLE_PERIOD:  sample_period_q  <= cfg_wdata[30:0];
				REG_DEAD_BAND:      dead_band_q      <= cfg_wdata[30:0];
				REG_DIRECT_ACTION:  direct_action_q  <= cfg_wdata[0];
				REG_LOOP_KIND:      loop_kind_q      <= cfg_wdata[2:0];
				REG_LOOP_ON:        loop_on_q        <= cfg_wdata[0];
				REG_DERIVATIVE_OFF: derivative_off_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q  <= direct_action_q ? (sp_e - pv_e) : (pv_e - sp_e);
			deriv_q <= q16_t'(s_axis_tdata[95:64]);
			lim_q   <= s_axis_tdata[96];
		end
		if (state_q == S_ERR) begin
			in_band_q <= !(d_minus > 0) && !(d_plus < 0);
			if (d_minus > 0)
				err_q <= sat34(d_minus);
			else if (d_plus < 0)
				err_q <= sat34(d_plus);
			else
				err_q <= '0;
		end
		if (state_q == S_MULI) begin
			pterm_q <= sat_shift16(mul_p);
		end
		if (state_q == S_SATI) begin
			iterm_q <= sat_shift16(mul_p);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			m_valid_q    <= 1'b0;
			held_error_q <= '0;
			held_prop_q  <= '0;
			held_step_q  <= '0;
			held_drive_q <= '0;
			held_goal_q  <= 1'b0;
			updated_q    <= 1'b0;
		end else begin
			if (m_axis_tready && state_q != S_DONE)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= (loop_on_q && gain_ok) ? S_ERR : S_DONE;
				end
				S_ERR:  state_q <= S_MULP;
				S_MULP: state_q <= S_MULI;
				S_MULI: state_q <= S_SATI;
				S_SATI: state_q <= S_MULT;
				S_MULT: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						updated_q <= loop_on_q;
						state_q   <= S_IDLE;
						if (loop_on_q) begin
							if (gain_ok) begin
								held_error_q <= err_q;
								held_prop_q  <= pterm_q;
								held_step_q  <= sat_shift16(mul_p);
								held_drive_q <= sat33(33'(pterm_q) + 33'(d_sel));
								held_goal_q  <= goal_next;
							end else begin
								held_prop_q  <= '0;
								held_step_q  <= '0;
								held_drive_q <= '0;
								held_goal_q  <= 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'b0, updated_q, held_goal_q, held_drive_q, held_step_q,
		held_prop_q, held_error_q};

	`CHK_PROP(a_busy_after_accept, clk, arst_n, accept |=> !s_axis_tready)
	`CHK_PROP(a_valid_from_done, clk, arst_n,
		$rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
	`CHK_PROP(a_low_gain_clears, clk, arst_n,
		(state_q == S_DONE && out_free && loop_on_q && !gain_ok) |=>
		(held_step_q == 0 && held_drive_q == 0 && held_goal_q))

endmodule

/* src/dbpi_mul.sv */
module dbpi_mul (
	input  logic           clk,
	input  logic           en,
	input  dbpi_pkg::q16_t a,
	input  dbpi_pkg::q16_t b,
	output dbpi_pkg::prod_t p
);
	import dbpi_pkg::*;

	prod_t p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod_t'(a) * prod_t'(b);
		end
	end

	assign p = p_q;

endmodule

/* bench/tb_deadband_pi_increment.sv */
module tb_deadband_pi_increment;
	import dbpi_pkg::*;

	localparam int GAIN_FLOOR_TB = 0;
	localparam int SEGMENTS      = 24;
	localparam int SEG_ITEMS     = 52;

	typedef struct packed {
		logic lim;
		q16_t dt;
		q16_t pv;
		q16_t sp;
	} sample_t;

	typedef struct packed {
		logic updated;
		logic goal_down;
		q16_t drive;
		q16_t step;
		q16_t prop;
		q16_t err;
	} result_t;

	typedef struct {
		logic        is_cfg;
		cfg_reg_t    addr;
		logic [31:0] wval;
		sample_t     smp;
		logic        typed;
		result_t     want;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;

	// shadow of the setup registers and the held outputs
	q16_t       kp = '0;
	q16_t       ki = '0;
	logic [30:0] ts = '0;
	logic [30:0] db = '0;
	logic       dir_act = 1'b1;
	logic [2:0] kind = KIND_HIGH;
	logic       loop_en = 1'b0;
	logic       d_off = 1'b0;
	result_t    held = '0;

	result_t   pending_results[$];
	plan_row_t plan[$];
	int        fail_cnt = 0;
	int        src_idle = 0;
	int        sink_stall = 0;
	logic      hold_go = 1'b0;
	logic      hold_off = 1'b0;

	deadband_pi_increment #(.GAIN_FLOOR(GAIN_FLOOR_TB)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic q16_t clip(longint v);
		if (v > longint'(Q16_MAX))
			return Q16_MAX;
		else if (v < longint'(Q16_MIN))
			return Q16_MIN;
		else
			return q16_t'(v);
	endfunction

	function automatic result_t pi_predict(sample_t s);
		longint diff, band, errv, tmp, d;
		logic   in_band;
		if (loop_en) begin
			if (longint'(kp) > GAIN_FLOOR_TB) begin
				diff = dir_act ? longint'(s.sp) - longint'(s.pv)
					: longint'(s.pv) - longint'(s.sp);
				band = longint'(db);
				in_band = (diff <= band) && (diff >= -band);
				if (in_band)
					errv = 0;
				else if (diff > 0)
					errv = diff - band;
				else
					errv = diff + band;
				held.err = clip(errv);
				held.prop = clip((longint'(kp) * longint'(held.err)) >>> 16);
				tmp = longint'(clip((longint'(ki) * longint'(held.err)) >>> 16));
				held.step = clip((tmp * longint'(ts)) >>> 16);
				d = d_off ? 0 : longint'(s.dt);
				if (in_band) begin
					if (kind == KIND_HIGH)
						held.goal_down = (s.lim == dir_act);
					else if (kind == KIND_LOW)
						held.goal_down = (s.lim != dir_act);
				end else begin
					held.goal_down = !(held.prop > 0);
				end
				held.drive = clip(longint'(held.prop) + d);
			end else begin
				held.prop = '0;
				held.step = '0;
				held.drive = '0;
				held.goal_down = 1'b1;
			end
		end
		held.updated = loop_en;
		return held;
	endfunction

	function automatic plan_row_t wr_row(cfg_reg_t a, logic [31:0] v);
		plan_row_t r;
		r = '{is_cfg: 1'b1, addr: a, wval: v, smp: '0, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic plan_row_t req_row(q16_t sp, q16_t pv, q16_t dt, logic lim);
		plan_row_t r;
		r = '{is_cfg: 1'b0, addr: REG_PROP_GAIN, wval: '0, smp: {lim, dt, pv, sp},
			typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic plan_row_t req_row_exp(q16_t sp, q16_t pv, q16_t dt, logic lim,
			result_t want);
		plan_row_t r;
		r = req_row(sp, pv, dt, lim);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic logic [31:0] corner_word();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'h0001_0000;
			4: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		int      r;
		longint  base, off;
		if ($urandom_range(9) < 2) begin
			s.sp = $urandom;
			s.pv = $urandom;
		end else begin
			r = $urandom;
			base = longint'(r) >>> $urandom_range(0, 20);
			case ($urandom_range(3))
				0: off = longint'(db);
				1: off = longint'(db) + 1;
				2: off = longint'($urandom_range(0, db));
				default: off = longint'(db) + longint'($urandom_range(0, 32'h0004_0000));
			endcase
			if ($urandom_range(1))
				off = -off;
			s.sp = q16_t'(base);
			s.pv = q16_t'(base + off);
		end
		case ($urandom_range(5))
			0: s.dt = Q16_MAX;
			1: s.dt = Q16_MIN;
			2: s.dt = $urandom;
			default: begin
				r = $urandom;
				s.dt = q16_t'(r >>> $urandom_range(4, 16));
			end
		endcase
		s.lim = 1'($urandom_range(1));
		return s;
	endfunction

	task automatic field_cmp(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic write_reg(cfg_reg_t a, logic [31:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v;
		case (a)
			REG_PROP_GAIN:      kp = v;
			REG_INTEGRAL_GAIN:  ki = v;
			REG_SAMPLE_PERIOD:  ts = v[30:0];
			REG_DEAD_BAND:      db = v[30:0];
			REG_DIRECT_ACTION:  dir_act = v[0];
			REG_LOOP_KIND:      kind = v[2:0];
			REG_LOOP_ON:        loop_en = v[0];
			REG_DERIVATIVE_OFF: d_off = v[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_req(sample_t smp, logic typed, result_t want);
		result_t pred;
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'(smp);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = pi_predict(smp);
		pending_results.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_axis_tready <= !hold_off && ($urandom_range(99) >= sink_stall);

	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				field_cmp("error_value", want.err, got.err);
				field_cmp("prop_term", want.prop, got.prop);
				field_cmp("integral_step", want.step, got.step);
				field_cmp("drive_term", want.drive, got.drive);
				field_cmp("goal_down", 32'(want.goal_down), 32'(got.goal_down));
				field_cmp("updated", 32'(want.updated), 32'(got.updated));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		// loop off after reset: zeros held
		plan.push_back(req_row_exp(Q16_MAX, Q16_MIN, Q16_MAX, 1'b1, '0));
		plan.push_back(wr_row(REG_LOOP_ON, 32'h1));
		// gain at floor, then negative gain
		plan.push_back(req_row_exp(32'sh0005_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0,
			{1'b1, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0}));
		plan.push_back(wr_row(REG_PROP_GAIN, 32'h8000_0000));
		plan.push_back(req_row_exp(32'sh0005_0000, 32'sh0001_0000, Q16_MIN, 1'b1,
			{1'b1, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0}));
		// unity gain, widest error both ways
		plan.push_back(wr_row(REG_PROP_GAIN, 32'h0001_0000));
		plan.push_back(req_row_exp(Q16_MAX, Q16_MIN, 32'sd0, 1'b0,
			{1'b1, 1'b0, Q16_MAX, 32'sd0, Q16_MAX, Q16_MAX}));
		plan.push_back(req_row_exp(Q16_MIN, Q16_MAX, Q16_MIN, 1'b0,
			{1'b1, 1'b1, Q16_MIN, 32'sd0, Q16_MIN, Q16_MIN}));
		plan.push_back(wr_row(REG_INTEGRAL_GAIN, 32'h7fff_ffff));
		plan.push_back(wr_row(REG_SAMPLE_PERIOD, 32'hffff_ffff));
		plan.push_back(wr_row(REG_DEAD_BAND, 32'h0002_0000));
		// deadband edge, high-limit kind
		plan.push_back(req_row(32'sh0003_0000, 32'sh0001_0000, 32'sh0000_1000, 1'b1));
		plan.push_back(req_row(32'sh0003_0000, 32'sh0001_0000, 32'sh0000_1000, 1'b0));
		plan.push_back(req_row(32'sh0001_0000, 32'sh0003_0001, 32'sh0000_1000, 1'b0));
		plan.push_back(req_row(32'sh0003_0001, 32'sh0001_0000, -32'sh0000_1000, 1'b1));
		plan.push_back(wr_row(REG_DIRECT_ACTION, 32'h0));
		plan.push_back(req_row(32'sh0002_0000, 32'sh0001_0000, 32'sd0, 1'b0));
		plan.push_back(req_row(32'sh0001_0000, 32'sh0004_0000, 32'sd0, 1'b1));
		plan.push_back(wr_row(REG_LOOP_KIND, 32'h7));
		plan.push_back(req_row(32'sh0002_0000, 32'sh0001_0000, 32'sd0, 1'b0));
		plan.push_back(req_row(32'sh0002_0000, 32'sh0001_0000, 32'sd0, 1'b1));
		plan.push_back(wr_row(REG_LOOP_KIND, 32'h2));
		plan.push_back(req_row(32'sh0001_0000, 32'sh0001_0000, 32'sd0, 1'b0));
		plan.push_back(wr_row(REG_LOOP_KIND, 32'h0));
		plan.push_back(req_row(32'sh0005_0000, 32'sh0001_0000, 32'sd0, 1'b1));
		plan.push_back(req_row(32'sh0001_0000, 32'sh0001_8000, 32'sd0, 1'b0));
		plan.push_back(wr_row(REG_DERIVATIVE_OFF, 32'h1));
		plan.push_back(req_row(32'sh0000_0000, 32'sh0100_0000, Q16_MAX, 1'b0));
		plan.push_back(wr_row(REG_DERIVATIVE_OFF, 32'h0));
		plan.push_back(wr_row(REG_PROP_GAIN, 32'h7fff_ffff));
		plan.push_back(req_row(32'sd0, Q16_MAX, Q16_MAX, 1'b1));
		plan.push_back(req_row(32'sh0000_4000, 32'sd0, Q16_MIN, 1'b0));
		plan.push_back(wr_row(REG_DEAD_BAND, 32'h7fff_ffff));
		plan.push_back(req_row(Q16_MAX, Q16_MIN, 32'sd0, 1'b0));
		plan.push_back(req_row(32'sd0, 32'sd0, 32'sd0, 1'b1));
		plan.push_back(wr_row(REG_LOOP_ON, 32'h0));
		plan.push_back(req_row(32'sh1234_5678, -32'sh0765_4321, Q16_MAX, 1'b1));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].addr, plan[i].wval);
			else
				send_req(plan[i].smp, plan[i].typed, plan[i].want);
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			@(posedge clk);
			case (seg % 4)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 86; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 86; end
				default: begin src_idle = 18; sink_stall = 18; end
			endcase
			@(negedge clk);
			write_reg(REG_PROP_GAIN, ($urandom_range(4) == 0) ? corner_word()
				: $urandom_range(1, 32'h0040_0000));
			write_reg(REG_INTEGRAL_GAIN, ($urandom_range(3) == 0) ? corner_word()
				: $urandom_range(0, 32'h0080_0000) - 32'h0040_0000);
			write_reg(REG_SAMPLE_PERIOD, ($urandom_range(3) == 0) ? corner_word()
				: $urandom_range(0, 32'h0002_0000));
			write_reg(REG_DEAD_BAND, ($urandom_range(3) == 0) ? corner_word()
				: $urandom_range(0, 32'h0004_0000));
			write_reg(REG_DIRECT_ACTION, $urandom);
			write_reg(REG_LOOP_KIND, $urandom);
			write_reg(REG_LOOP_ON, {16'($urandom_range(32'hffff)), 15'd0,
				($urandom_range(9) != 0)});
			write_reg(REG_DERIVATIVE_OFF, 32'($urandom_range(3) == 0));
			if (seg == 4)
				hold_go = 1'b1;
			for (int n = 0; n < SEG_ITEMS; n++)
				send_req(rand_sample(), 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
